FILE: design/acsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsi_pkg
// Shared types, character codes and command codes for the CSI parser.
// ----------------------------------------------------------------------------
package acsi_pkg;

  localparam int MAX_PARAMS = 5;
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARAMS);

  // bytes of interest
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_DIGIT0   = 8'h30;
  localparam logic [7:0] CH_DIGIT9   = 8'h39;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;
  localparam logic [7:0] CH_ED       = 8'h4A;  // 'J'
  localparam logic [7:0] CH_CUF      = 8'h43;  // 'C'
  localparam logic [7:0] CH_CUB      = 8'h44;  // 'D'
  localparam logic [7:0] CH_SGR      = 8'h6D;  // 'm'

  // parameter values matched at dispatch
  localparam logic [31:0] ED_ALL     = 32'd2;
  localparam logic [31:0] SGR_RESET  = 32'd0;
  localparam logic [31:0] SGR_FG_EXT = 32'd38;
  localparam logic [31:0] SGR_BG_EXT = 32'd48;
  localparam logic [31:0] SGR_RGB    = 32'd2;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FIVE = CNT_W'(5);

  // configuration register indexes
  localparam logic [1:0] REG_ACCEPT = 2'd0;
  localparam logic [1:0] REG_DEF_FG = 2'd1;
  localparam logic [1:0] REG_DEF_BG = 2'd2;

  localparam logic [23:0] DEF_FG_RESET = 24'h00FF00;
  localparam logic [23:0] DEF_BG_RESET = 24'h000000;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ESC  = 3'b010,
    ST_CSI  = 3'b100
  } esc_state_t;

  typedef enum logic [3:0] {
    CMD_PRINT = 4'd0,
    CMD_LF    = 4'd1,
    CMD_CR    = 4'd2,
    CMD_BS    = 4'd3,
    CMD_CLEAR = 4'd4,
    CMD_RIGHT = 4'd5,
    CMD_LEFT  = 4'd6,
    CMD_FG    = 4'd7,
    CMD_BG    = 4'd8,
    CMD_RESET = 4'd9
  } cmd_t;

  typedef struct packed {
    esc_state_t                        esc_st;
    logic [MAX_PARAMS-1:0][31:0]       params;
    logic [CNT_W-1:0]                  count;
    logic [31:0]                       cur;
    logic                              has_digit;
  } parse_st_t;

  typedef struct packed {
    logic        accept_enable;
    logic [23:0] def_fg;
    logic [23:0] def_bg;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  char_code;
    logic [23:0] fg_color;
    logic [23:0] bg_rgb;
  } result_t;

endpackage

FILE: design/ansi_csi_escape_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_csi_escape_parser
// An accepted input word passes the input register, then the result
// register, which presents its command word. The escape state loop closes
// through the state register. One byte per cycle unless the output stalls.
// Bytes that make no command leave no output word.
// Reset (rst_n, synchronous): both stages empty, parser idle, parameters
// cleared, registers at defaults (accept on, fg 0x00FF00, bg 0x000000).
// ----------------------------------------------------------------------------
module ansi_csi_escape_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_in
  // command stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [3:0] command, [11:4] char_code,
                                   // [35:12] fg_color, [59:36] bg_rgb, [63:60] zero
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  // Input stage: one byte register. It moves on whenever the result
  // register is empty or being drained, so a byte may sit here while a
  // finished command still waits at the output.
  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               adv;
  logic               s1_fire;

  acsi_pkg::cfg_t      cfg_r;
  acsi_pkg::parse_st_t st_r;
  acsi_pkg::parse_st_t st_nxt;
  logic                res_valid;
  acsi_pkg::result_t   res;

  assign adv       = !out_tvalid || out_tready;
  assign s1_fire   = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Configuration registers; out-of-range index ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accept_enable <= 1'b1;
      cfg_r.def_fg        <= acsi_pkg::DEF_FG_RESET;
      cfg_r.def_bg        <= acsi_pkg::DEF_BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acsi_pkg::REG_ACCEPT: cfg_r.accept_enable <= cfg_wdata[0];
        acsi_pkg::REG_DEF_FG: cfg_r.def_fg        <= cfg_wdata;
        acsi_pkg::REG_DEF_BG: cfg_r.def_bg        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser state: updated once per byte as it leaves the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{esc_st: acsi_pkg::ST_IDLE, params: '0, count: '0, cur: '0,
                has_digit: 1'b0};
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  acsi_decode u_decode (
    .st        (st_r),
    .cfg       (cfg_r),
    .byte_in   (s1_byte_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: loads a word only when the byte produced a command.
  acsi_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv),
    .res_valid  (s1_fire && res_valid),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.count <= acsi_pkg::MAX_CNT)
    else $error("parameter count beyond cap");

  a_disabled_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !cfg_r.accept_enable) |=> !out_tvalid)
    else $error("command produced while disabled");

  a_esc_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && st_r.esc_st == acsi_pkg::ST_ESC) |=> !out_tvalid)
    else $error("command produced for byte after ESC");

  a_idle_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && cfg_r.accept_enable && st_r.esc_st == acsi_pkg::ST_IDLE &&
     s1_byte_r != acsi_pkg::CH_ESC) |=> out_tvalid)
    else $error("idle byte lost");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

endmodule

FILE: design/acsi_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsi_decode
// Next-state and command logic for one byte against the parser state.
// ----------------------------------------------------------------------------
module acsi_decode (
  input  acsi_pkg::parse_st_t st,
  input  acsi_pkg::cfg_t      cfg,
  input  logic [7:0]          byte_in,
  output acsi_pkg::parse_st_t st_nxt,
  output logic                res_valid,
  output acsi_pkg::result_t   res
);

  logic                                  room;
  logic                                  take_last;
  logic [acsi_pkg::MAX_PARAMS-1:0][31:0] push_params;
  logic [acsi_pkg::CNT_W-1:0]            push_count;
  logic [acsi_pkg::MAX_PARAMS-1:0][31:0] fin_params;
  logic [acsi_pkg::CNT_W-1:0]            fin_count;
  logic [31:0]                           cur_x10;
  logic [23:0]                           rgb;
  logic                                  is_final;
  logic                                  is_digit;

  // append current value if there is room
  always_comb begin
    room        = st.count < acsi_pkg::MAX_CNT;
    push_params = st.params;
    for (int i = 0; i < acsi_pkg::MAX_PARAMS; i++) begin
      if (room && (st.count == acsi_pkg::CNT_W'(i))) begin
        push_params[i] = st.cur;
      end
    end
    push_count = room ? st.count + acsi_pkg::CNT_ONE : st.count;
  end

  assign take_last  = st.has_digit || (st.count != '0);
  assign fin_params = take_last ? push_params : st.params;
  assign fin_count  = take_last ? push_count  : st.count;
  assign cur_x10    = 32'({st.cur[28:0], 3'b000} + {st.cur[30:0], 1'b0});
  assign rgb        = {fin_params[2][7:0], fin_params[3][7:0], fin_params[4][7:0]};
  assign is_final   = (byte_in >= acsi_pkg::FINAL_LO) && (byte_in <= acsi_pkg::FINAL_HI);
  assign is_digit   = (byte_in >= acsi_pkg::CH_DIGIT0) && (byte_in <= acsi_pkg::CH_DIGIT9);

  always_comb begin
    st_nxt        = st;
    res_valid     = 1'b0;
    res.cmd       = acsi_pkg::CMD_PRINT;
    res.char_code = '0;
    res.fg_color  = '0;
    res.bg_rgb    = '0;
    if (cfg.accept_enable) begin
      unique case (st.esc_st)
        acsi_pkg::ST_ESC: begin
          if (byte_in == acsi_pkg::CH_LBRACKET) begin
            st_nxt.esc_st    = acsi_pkg::ST_CSI;
            st_nxt.count     = '0;
            st_nxt.cur       = '0;
            st_nxt.has_digit = 1'b0;
          end else begin
            st_nxt.esc_st = acsi_pkg::ST_IDLE;
          end
        end
        acsi_pkg::ST_CSI: begin
          if (is_final) begin
            st_nxt.esc_st = acsi_pkg::ST_IDLE;
            st_nxt.params = fin_params;
            st_nxt.count  = fin_count;
            priority if (byte_in == acsi_pkg::CH_ED && fin_count == acsi_pkg::CNT_ONE &&
                         fin_params[0] == acsi_pkg::ED_ALL) begin
              res_valid = 1'b1;
              res.cmd   = acsi_pkg::CMD_CLEAR;
            end else if (byte_in == acsi_pkg::CH_CUF && fin_count == '0) begin
              res_valid = 1'b1;
              res.cmd   = acsi_pkg::CMD_RIGHT;
            end else if (byte_in == acsi_pkg::CH_CUB && fin_count == '0) begin
              res_valid = 1'b1;
              res.cmd   = acsi_pkg::CMD_LEFT;
            end else if (byte_in == acsi_pkg::CH_SGR) begin
              priority if (fin_count == acsi_pkg::CNT_ONE &&
                           fin_params[0] == acsi_pkg::SGR_RESET) begin
                res_valid    = 1'b1;
                res.cmd      = acsi_pkg::CMD_RESET;
                res.fg_color = cfg.def_fg;
                res.bg_rgb   = cfg.def_bg;
              end else if (fin_count == acsi_pkg::CNT_FIVE &&
                           fin_params[0] == acsi_pkg::SGR_FG_EXT &&
                           fin_params[1] == acsi_pkg::SGR_RGB) begin
                res_valid    = 1'b1;
                res.cmd      = acsi_pkg::CMD_FG;
                res.fg_color = rgb;
              end else if (fin_count == acsi_pkg::CNT_FIVE &&
                           fin_params[0] == acsi_pkg::SGR_BG_EXT &&
                           fin_params[1] == acsi_pkg::SGR_RGB) begin
                res_valid    = 1'b1;
                res.cmd      = acsi_pkg::CMD_BG;
                res.bg_rgb   = rgb;
              end else begin
                res_valid = 1'b0;
              end
            end else begin
              res_valid = 1'b0;
            end
          end else if (is_digit) begin
            st_nxt.cur       = 32'(cur_x10 + {28'd0, byte_in[3:0]});
            st_nxt.has_digit = 1'b1;
          end else if (byte_in == acsi_pkg::CH_SEMI) begin
            st_nxt.params    = push_params;
            st_nxt.count     = push_count;
            st_nxt.cur       = '0;
            st_nxt.has_digit = 1'b0;
          end
        end
        default: begin
          // idle
          if (byte_in == acsi_pkg::CH_ESC) begin
            st_nxt.esc_st = acsi_pkg::ST_ESC;
          end else begin
            res_valid = 1'b1;
            priority if (byte_in == acsi_pkg::CH_LF) begin
              res.cmd = acsi_pkg::CMD_LF;
            end else if (byte_in == acsi_pkg::CH_CR) begin
              res.cmd = acsi_pkg::CMD_CR;
            end else if (byte_in == acsi_pkg::CH_BS) begin
              res.cmd = acsi_pkg::CMD_BS;
            end else begin
              res.cmd       = acsi_pkg::CMD_PRINT;
              res.char_code = byte_in;
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: design/acsi_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsi_out_reg
// Result register: holds one command word until the sink takes it.
// ----------------------------------------------------------------------------
module acsi_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,       // register may take a new word
  input  logic              res_valid,
  input  acsi_pkg::result_t res,
  output logic              out_tvalid,
  output logic [63:0]       out_tdata
);

  logic        valid_r;
  logic [63:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data_r <= {4'd0, res.bg_rgb, res.fg_color, res.char_code, res.cmd};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

FILE: tb/tb_ansi_csi_escape_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_csi_escape_parser
// Self-checking bench for the CSI escape parser. A short directed table
// walks every command, then random text, control bytes and CSI sequences
// (well formed, near misses, junk-laden, huge and empty parameters) are
// checked word by word against a behavioural decoder held in the bench,
// over several register settings.
// ----------------------------------------------------------------------------
module tb_ansi_csi_escape_parser;
  import acsi_pkg::*;

  // index 3 decodes to no register; writes there must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // parameter list markers for the sequence builder
  localparam longint P_EMPTY = -1;
  localparam longint P_HUGE  = -2;

  localparam int IDLE_PCT  = 25;
  localparam int HOLD_AT   = 150;   // bytes accepted before the long receiver hold
  localparam int HOLD_LEN  = 300;   // cycles of that hold
  localparam int QUIET_LO  = 500;   // window of bytes with no idling on either side
  localparam int QUIET_HI  = 700;
  localparam int SETTLE    = 8;     // covers the two-stage pipe with margin

  // one row of the directed table; want is only used when pinned is set
  typedef struct packed {
    logic [7:0] code;
    logic       pinned;
    result_t    want;
  } stim_row_t;

  function automatic stim_row_t go(input logic [7:0] code);
    stim_row_t r;
    r = '0;
    r.code = code;
    return r;
  endfunction

  function automatic stim_row_t pin(input logic [7:0] code, input cmd_t c,
                                    input logic [7:0] ch, input logic [23:0] fg,
                                    input logic [23:0] bg);
    stim_row_t r;
    r.code           = code;
    r.pinned         = 1'b1;
    r.want.cmd       = c;
    r.want.char_code = ch;
    r.want.fg_color  = fg;
    r.want.bg_rgb    = bg;
    return r;
  endfunction

  // Directed table. Only rows whose result is obvious carry a typed
  // expectation; the rest go through the decoder.
  localparam int N_DIR = 45;
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    pin(8'h00, CMD_PRINT, 8'h00, 24'h0, 24'h0),    // lowest byte prints
    pin(8'hFF, CMD_PRINT, 8'hFF, 24'h0, 24'h0),    // highest byte prints
    pin(CH_LF, CMD_LF, 8'h00, 24'h0, 24'h0),
    pin(CH_CR, CMD_CR, 8'h00, 24'h0, 24'h0),
    pin(CH_BS, CMD_BS, 8'h00, 24'h0, 24'h0),
    go(CH_ESC), go(CH_LBRACKET), go(CH_DIGIT0 + 8'd2),              // ESC[2J
    pin(CH_ED, CMD_CLEAR, 8'h00, 24'h0, 24'h0),
    go(CH_ESC), go(CH_LBRACKET),                                    // ESC[C
    pin(CH_CUF, CMD_RIGHT, 8'h00, 24'h0, 24'h0),
    go(CH_ESC), go(CH_LBRACKET),                                    // ESC[D
    pin(CH_CUB, CMD_LEFT, 8'h00, 24'h0, 24'h0),
    go(CH_ESC), go(CH_LBRACKET), go(CH_DIGIT0),                     // ESC[0m
    pin(CH_SGR, CMD_RESET, 8'h00, DEF_FG_RESET, DEF_BG_RESET),
    go(CH_ESC), go(8'h41),                                          // ESC A swallowed
    pin(8'h41, CMD_PRINT, 8'h41, 24'h0, 24'h0),                     // back in idle
    go(CH_ESC), go(CH_LBRACKET), go(CH_DIGIT0 + 8'd3),              // ESC[38;2;;;m
    go(CH_DIGIT0 + 8'd8), go(CH_SEMI), go(CH_DIGIT0 + 8'd2),
    go(CH_SEMI), go(CH_SEMI), go(CH_SEMI),
    pin(CH_SGR, CMD_FG, 8'h00, 24'h000000, 24'h0),                  // empties count as 0
    go(CH_ESC), go(CH_LBRACKET), go(CH_DIGIT0 + 8'd4),              // ESC[48;2;;;255m
    go(CH_DIGIT0 + 8'd8), go(CH_SEMI), go(CH_DIGIT0 + 8'd2),
    go(CH_SEMI), go(CH_SEMI), go(CH_SEMI),
    go(CH_DIGIT0 + 8'd2), go(CH_DIGIT0 + 8'd5), go(CH_DIGIT0 + 8'd5),
    pin(CH_SGR, CMD_BG, 8'h00, 24'h0, 24'h0000FF)
  };

  // --------------------------------------------------------------------------
  // DUT hookup; every input known from time zero
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] byte_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;            // [3:0] command, [11:4] char_code,
                                     // [35:12] fg_color, [59:36] bg_rgb
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = REG_ACCEPT;
  logic [23:0] cfg_wdata  = 24'h0;

  ansi_csi_escape_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the parser: registers, escape state and parameter store
  // --------------------------------------------------------------------------
  logic        r_accept;
  logic [23:0] r_def_fg;
  logic [23:0] r_def_bg;

  esc_state_t  p_state;
  logic [31:0] p_params [MAX_PARAMS];
  int          p_count;
  logic [31:0] p_value;
  logic        p_has_digit;

  result_t     pending_cmds [$];     // command words still owed by the DUT

  int          bytes_sent;           // every input word accepted
  int          bytes_live;           // accepted while input was enabled
  int          bytes_dropped;
  int          words_checked;
  int          mismatches;
  int          cmd_hits [10];

  logic [7:0]  burst_q [$];          // bytes of the sequence being built
  int          junk_pct;

  task automatic clear_model();
    r_accept    = 1'b1;
    r_def_fg    = DEF_FG_RESET;
    r_def_bg    = DEF_BG_RESET;
    p_state     = ST_IDLE;
    p_count     = 0;
    p_value     = '0;
    p_has_digit = 1'b0;
    foreach (p_params[i]) p_params[i] = '0;
  endtask

  // append the running value unless the store is full
  function automatic void keep_param();
    if (p_count < MAX_PARAMS) begin
      p_params[p_count] = p_value;
      p_count++;
    end
  endfunction

  // Advance the bench parser by one byte; returns 1 when a command results.
  function automatic bit decode_byte(input logic [7:0] b, output result_t word);
    logic [23:0] rgb;
    word = '0;
    if (!r_accept) return 1'b0;   // dropped, state untouched
    case (p_state)
      ST_ESC: begin
        if (b == CH_LBRACKET) begin
          p_state     = ST_CSI;
          p_count     = 0;
          p_value     = '0;
          p_has_digit = 1'b0;
        end else begin
          p_state = ST_IDLE;      // anything else swallows the escape
        end
        return 1'b0;
      end
      ST_CSI: begin
        if (b >= FINAL_LO && b <= FINAL_HI) begin
          // trailing parameter counts if it has a digit or follows a ';'
          if (p_has_digit || p_count > 0) keep_param();
          p_state = ST_IDLE;
          rgb = {p_params[2][7:0], p_params[3][7:0], p_params[4][7:0]};
          if (b == CH_ED && p_count == 1 && p_params[0] == ED_ALL) begin
            word.cmd = CMD_CLEAR;
            return 1'b1;
          end
          if (b == CH_CUF && p_count == 0) begin
            word.cmd = CMD_RIGHT;
            return 1'b1;
          end
          if (b == CH_CUB && p_count == 0) begin
            word.cmd = CMD_LEFT;
            return 1'b1;
          end
          if (b == CH_SGR) begin
            if (p_count == 1 && p_params[0] == SGR_RESET) begin
              word.cmd      = CMD_RESET;
              word.fg_color = r_def_fg;
              word.bg_rgb   = r_def_bg;
              return 1'b1;
            end
            if (p_count == MAX_PARAMS && p_params[0] == SGR_FG_EXT
                && p_params[1] == SGR_RGB) begin
              word.cmd      = CMD_FG;
              word.fg_color = rgb;
              return 1'b1;
            end
            if (p_count == MAX_PARAMS && p_params[0] == SGR_BG_EXT
                && p_params[1] == SGR_RGB) begin
              word.cmd      = CMD_BG;
              word.bg_rgb   = rgb;
              return 1'b1;
            end
          end
          return 1'b0;
        end
        if (b >= CH_DIGIT0 && b <= CH_DIGIT9) begin
          p_value     = p_value * 32'd10 + 32'(b - CH_DIGIT0);   // wraps at 2^32
          p_has_digit = 1'b1;
        end else if (b == CH_SEMI) begin
          keep_param();           // an empty field still counts, as 0
          p_value     = '0;
          p_has_digit = 1'b0;
        end
        return 1'b0;              // every other byte is ignored inside CSI
      end
      default: begin
        if (b == CH_ESC) begin
          p_state = ST_ESC;
          return 1'b0;
        end
        case (b)
          CH_LF:   word.cmd = CMD_LF;
          CH_CR:   word.cmd = CMD_CR;
          CH_BS:   word.cmd = CMD_BS;
          default: begin
            word.cmd       = CMD_PRINT;
            word.char_code = b;
          end
        endcase
        return 1'b1;
      end
    endcase
  endfunction

  function automatic bit quiet_now();
    return bytes_sent >= QUIET_LO && bytes_sent < QUIET_HI;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Called and returns at a falling edge.
  // --------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input logic pinned, input result_t want);
    result_t got_pred;
    bit      has;
    bit      live;
    while (!quiet_now() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // word taken at this edge: run it through the bench parser
    live = r_accept;
    has  = decode_byte(b, got_pred);
    if (pinned) pending_cmds.push_back(want);
    else if (has) pending_cmds.push_back(got_pred);
    bytes_sent++;
    if (live) bytes_live++;
    else bytes_dropped++;
    @(negedge clk);
  endtask

  // drop valid, wait for every owed word, then let the pipe empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // register write; only issued while the pipe is empty
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ACCEPT: r_accept = data[0];
      REG_DEF_FG: r_def_fg = data;
      REG_DEF_BG: r_def_bg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random sequence builder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_junk();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(8'h00, 8'h2F));
      1:       return ($urandom_range(0, 1) != 0) ? 8'h3A : 8'($urandom_range(8'h3C, 8'h3F));
      2:       return 8'($urandom_range(8'h7F, 8'hFF));
      3:       return CH_ESC;
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  function automatic longint pick_param();
    case ($urandom_range(0, 9))
      0:       return P_EMPTY;
      1:       return P_HUGE;
      2:       return longint'(SGR_RESET);
      3:       return longint'(ED_ALL);
      4:       return longint'(SGR_FG_EXT);
      5:       return longint'(SGR_BG_EXT);
      6, 7:    return longint'($urandom_range(0, 255));
      8:       return longint'($urandom_range(0, 99999));
      default: return ($urandom_range(0, 1) != 0) ? 64'd4294967295 : 64'd4294967296;
    endcase
  endfunction

  // byte into the burst, with an optional ignorable byte slipped in ahead
  task automatic put_seq(input logic [7:0] b);
    if (junk_pct != 0 && $urandom_range(0, 99) < junk_pct)
      burst_q.push_back(pick_junk());
    burst_q.push_back(b);
  endtask

  task automatic add_plist(input longint pl [$]);
    string s;
    for (int i = 0; i < pl.size(); i++) begin
      if (i != 0) put_seq(CH_SEMI);
      if (pl[i] == P_HUGE) begin
        repeat ($urandom_range(10, 12)) put_seq(CH_DIGIT0 + 8'($urandom_range(0, 9)));
      end else if (pl[i] != P_EMPTY) begin
        if ($urandom_range(0, 6) == 0) put_seq(CH_DIGIT0);   // leading zero
        s = $sformatf("%0d", pl[i]);
        for (int j = 0; j < s.len(); j++) put_seq(8'(s[j]));
      end
    end
  endtask

  function automatic longint colour_part();
    return ($urandom_range(0, 7) == 0) ? pick_param() : longint'($urandom_range(0, 300));
  endfunction

  task automatic build_burst();
    int         kind;
    logic [7:0] b;
    longint     pl [$];
    junk_pct = 0;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      // plain text, now and then any byte at all
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 9) < 3) b = 8'($urandom_range(0, 255));
        else b = 8'($urandom_range(8'h20, 8'h7E));
        burst_q.push_back(b);
      end
    end else if (kind < 25) begin
      case ($urandom_range(0, 2))
        0:       burst_q.push_back(CH_LF);
        1:       burst_q.push_back(CH_CR);
        default: burst_q.push_back(CH_BS);
      endcase
    end else if (kind < 30) begin
      // escape not followed by '[' is swallowed
      burst_q.push_back(CH_ESC);
      do b = 8'($urandom_range(0, 255)); while (b == CH_LBRACKET);
      burst_q.push_back(b);
    end else begin
      burst_q.push_back(CH_ESC);
      burst_q.push_back(CH_LBRACKET);
      if ($urandom_range(0, 4) == 0) junk_pct = 20;
      case ($urandom_range(0, 9))
        0: begin
          pl = '{longint'(ED_ALL)};
          add_plist(pl);
          put_seq(CH_ED);
        end
        1: put_seq(CH_CUF);
        2: put_seq(CH_CUB);
        3: begin
          if ($urandom_range(0, 9) != 0) begin
            pl = '{longint'(SGR_RESET)};
            add_plist(pl);
          end
          put_seq(CH_SGR);
        end
        4, 5, 6: begin
          pl = '{($urandom_range(0, 1) != 0) ? longint'(SGR_FG_EXT) : longint'(SGR_BG_EXT),
                 longint'(SGR_RGB), colour_part(), colour_part(), colour_part()};
          add_plist(pl);
          put_seq(CH_SGR);
        end
        7: begin
          // arbitrary list, may overflow the store, arbitrary final byte
          repeat ($urandom_range(0, 8)) pl.push_back(pick_param());
          add_plist(pl);
          put_seq(8'($urandom_range(FINAL_LO, FINAL_HI)));
        end
        8: begin
          junk_pct = 35;
          pl = '{($urandom_range(0, 1) != 0) ? longint'(SGR_FG_EXT) : longint'(SGR_BG_EXT),
                 longint'(SGR_RGB), colour_part(), colour_part(), colour_part()};
          repeat ($urandom_range(0, 2)) pl.push_back(pick_param());
          add_plist(pl);
          put_seq(CH_SGR);
        end
        default: begin
          // near misses: lists of varied length, often wrong for the dispatched finals
          pl = '{longint'(SGR_FG_EXT), longint'(SGR_RGB)};
          repeat ($urandom_range(0, 5)) pl.push_back(pick_param());
          if ($urandom_range(0, 2) == 0) pl = '{longint'($urandom_range(0, 5))};
          add_plist(pl);
          case ($urandom_range(0, 3))
            0:       put_seq(CH_CUF);
            1:       put_seq(CH_CUB);
            2:       put_seq(CH_ED);
            default: put_seq(CH_SGR);
          endcase
        end
      endcase
    end
  endtask

  task automatic run_random(input int upto);
    while (bytes_live < upto) begin
      build_burst();
      while (burst_q.size() != 0) put_byte(burst_q.pop_front(), 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold, and a quiet window
  // --------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && bytes_sent >= HOLD_AT) begin
      // sender keeps offering while this runs, so the block must back up
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else if (quiet_now()) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each command word against the oldest owed word
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t mismatch (%s): want cmd=%0d ch=%02h fg=%06h bg=%06h,",
                " got cmd=%0d ch=%02h fg=%06h bg=%06h"},
               $time, what, want.cmd, want.char_code, want.fg_color, want.bg_rgb,
               got.cmd, got.char_code, got.fg_color, got.bg_rgb);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cmd       = cmd_t'(out_tdata[3:0]);
      got.char_code = out_tdata[11:4];
      got.fg_color  = out_tdata[35:12];
      got.bg_rgb    = out_tdata[59:36];
      if (pending_cmds.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = pending_cmds.pop_front();
        words_checked++;
        if (got.cmd !== want.cmd || got.char_code !== want.char_code
            || got.fg_color !== want.fg_color || got.bg_rgb !== want.bg_rgb)
          note_mismatch("field", want, got);
        else if (out_tdata[63:60] !== 4'h0)
          note_mismatch("padding not zero", want, got);
        else
          cmd_hits[int'(got.cmd)]++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bytes_sent    = 0;
    bytes_live    = 0;
    bytes_dropped = 0;
    words_checked = 0;
    mismatches    = 0;
    foreach (cmd_hits[i]) cmd_hits[i] = 0;
    clear_model();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows, registers still at their reset values
    for (int i = 0; i < N_DIR; i++)
      put_byte(DIR_ROWS[i].code, DIR_ROWS[i].pinned, DIR_ROWS[i].want);

    // random colours
    settle();
    write_reg(REG_DEF_FG, 24'($urandom()));
    write_reg(REG_DEF_BG, 24'($urandom()));
    write_reg(REG_ACCEPT, 24'd1);
    run_random(330);

    // all-ones defaults
    settle();
    write_reg(REG_DEF_FG, 24'hFFFFFF);
    write_reg(REG_DEF_BG, 24'hFFFFFF);
    run_random(640);

    // all-zero defaults, input off for a while, stray write to the hole
    settle();
    write_reg(REG_DEF_FG, 24'h000000);
    write_reg(REG_DEF_BG, 24'h000000);
    write_reg(REG_ACCEPT, 24'd0);
    write_reg(REG_UNUSED, 24'($urandom()));
    repeat (60) put_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    settle();
    write_reg(REG_ACCEPT, 24'd1);
    run_random(950);

    settle();
    repeat (10) @(posedge clk);

    if (pending_cmds.size() != 0) begin
      mismatches++;
      $display("%0d command words never arrived", pending_cmds.size());
    end
    $display("Covered %0d bytes (%0d dropped with input off), %0d command words checked",
             bytes_sent, bytes_dropped, words_checked);
    $display({"  print %0d, lf %0d, cr %0d, bs %0d, clear %0d,",
              " right %0d, left %0d, fg %0d, bg %0d, reset %0d"},
             cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3], cmd_hits[4],
             cmd_hits[5], cmd_hits[6], cmd_hits[7], cmd_hits[8], cmd_hits[9]);
    if (mismatches == 0) begin
      $display("PASS ansi_csi_escape_parser");
    end else begin
      $display("FAIL ansi_csi_escape_parser");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #200000;
    $display("FAIL ansi_csi_escape_parser");
    $finish;
  end

endmodule

FILE: ansi_csi_escape_parser.f
design/acsi_pkg.sv
design/acsi_decode.sv
design/acsi_out_reg.sv
design/ansi_csi_escape_parser.sv
tb/tb_ansi_csi_escape_parser.sv
